### rtl/core/qwpr_pkg.sv
// Shared constants, codes and types of the positional-removal queue.
`default_nettype none
package qwpr_pkg;
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int POS_W   = 8;
    localparam int ST_W    = 2;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (OCC_W > POS_W) ? OCC_W : POS_W;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_REM  = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST = 2'd2;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_BEYOND = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic load;       // capture the incoming value
        logic take_next;  // shift toward the head
        logic take_head;  // wrap the head word into this cell
        logic sel;        // drive this cell's word onto the read bus
    } cell_ctl_t;
endpackage
`default_nettype wire

### rtl/core/qwpr_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none
interface qwpr_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [qwpr_pkg::OP_W-1:0]           opcode;
    logic signed [qwpr_pkg::DATA_W-1:0]  value;
    logic [qwpr_pkg::POS_W-1:0]          position;
    modport source(output valid, opcode, value, position, input ready);
    modport sink(input valid, opcode, value, position, output ready);
endinterface

interface qwpr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [qwpr_pkg::ST_W-1:0]           status;
    logic signed [qwpr_pkg::DATA_W-1:0]  data;
    logic                                last;
    modport source(output valid, status, data, last, input ready);
    modport sink(input valid, status, data, last, output ready);
endinterface
`default_nettype wire

### rtl/core/qwpr_cell.sv
// One storage cell of the queue chain.
`default_nettype none
module qwpr_cell (
    input  wire logic                               clk,
    input  wire qwpr_pkg::cell_ctl_t                ctl,
    input  wire logic signed [qwpr_pkg::DATA_W-1:0] value,
    input  wire logic signed [qwpr_pkg::DATA_W-1:0] next_word,
    input  wire logic signed [qwpr_pkg::DATA_W-1:0] head_word,
    output logic signed [qwpr_pkg::DATA_W-1:0]      word,
    output logic signed [qwpr_pkg::DATA_W-1:0]      tap
);
    logic signed [qwpr_pkg::DATA_W-1:0] data_reg;
    logic signed [qwpr_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
        begin
            data_next = value;
        end
        else if (ctl.take_next)
        begin
            data_next = next_word;
        end
        else if (ctl.take_head)
        begin
            data_next = head_word;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;
    assign tap  = ctl.sel ? data_reg : '0;
endmodule
`default_nettype wire

### rtl/core/queue_with_positional_removal_top.sv
// Bounded queue with removal at any position, built as a chain of shifting cells.
// Every result word is registered in the output register in the cycle after its cause.
// Enqueue and remove shift cells in parallel, one per cycle if output is free and no list runs.
// List emits each stored word in order while output is free; the chain rotates once per word.
// Reset clears the occupancy count, the list sequencer and the output valid flag.
// Cell contents are undefined until written; only occupied cells are ever read.
`default_nettype none
module queue_with_positional_removal_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    qwpr_cmd_if.sink   cmd,
    qwpr_rsp_if.source rsp
);
    localparam int D = qwpr_pkg::DEPTH;

    logic [qwpr_pkg::OCC_W-1:0] occ_reg, occ_next;
    logic                       listing_reg, listing_next;
    logic [qwpr_pkg::IDX_W-1:0] cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;
    logic [qwpr_pkg::ST_W-1:0]  status_reg, status_next;
    logic signed [qwpr_pkg::DATA_W-1:0] data_reg, data_next;
    logic                       last_reg, last_next;

    logic signed [qwpr_pkg::DATA_W-1:0] words [D];
    logic signed [qwpr_pkg::DATA_W-1:0] taps  [D];
    qwpr_pkg::cell_ctl_t                ctls  [D];
    logic signed [qwpr_pkg::DATA_W-1:0] removed;

    logic                       out_free, acc, list_step, list_last;
    logic                       is_empty, is_full, beyond, enq_ok, rem_ok;
    logic [qwpr_pkg::CMP_W-1:0] occ_c, pos_c, idx_c;
    logic [qwpr_pkg::IDX_W-1:0] cnt_cur;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = !listing_reg && out_free;
    assign acc       = cmd.valid && cmd.ready;

    assign occ_c    = qwpr_pkg::CMP_W'(occ_reg);
    assign pos_c    = qwpr_pkg::CMP_W'(cmd.position);
    assign idx_c    = (cmd.position == '0) ? '0 : pos_c - qwpr_pkg::CMP_W'(1);
    assign is_empty = (occ_reg == '0);
    assign is_full  = (occ_reg == qwpr_pkg::OCC_W'(D));
    assign beyond   = pos_c > occ_c;
    assign enq_ok   = acc && (cmd.opcode == qwpr_pkg::OP_ENQ) && !is_full;
    assign rem_ok   = acc && (cmd.opcode == qwpr_pkg::OP_REM) && !is_empty && !beyond;

    // A list starts in the cycle it is accepted and then runs from the sequencer.
    assign list_step = out_free && (listing_reg ||
                       (acc && (cmd.opcode == qwpr_pkg::OP_LIST) && !is_empty));
    assign cnt_cur   = listing_reg ? cnt_reg : '0;
    assign list_last = (qwpr_pkg::OCC_W'(cnt_cur) == occ_reg - qwpr_pkg::OCC_W'(1));

    for (genvar i = 0; i < D; i++)
    begin : g_cell
        logic [qwpr_pkg::CMP_W-1:0]         pos_i;
        logic signed [qwpr_pkg::DATA_W-1:0] nxt;
        assign pos_i = qwpr_pkg::CMP_W'(i);
        if (i == D - 1)
        begin : g_tail
            assign nxt = '0;
        end
        else
        begin : g_mid
            assign nxt = words[i+1];
        end

        always_comb
        begin
            ctls[i].load      = enq_ok && (pos_i == occ_c);
            ctls[i].take_next = ((rem_ok && (pos_i >= idx_c)) || list_step)
                                && (pos_i + qwpr_pkg::CMP_W'(1) < occ_c);
            ctls[i].take_head = list_step && (pos_i + qwpr_pkg::CMP_W'(1) == occ_c);
            ctls[i].sel       = (pos_i == idx_c);
        end

        qwpr_cell u_cell (
            .clk       (clk),
            .ctl       (ctls[i]),
            .value     (cmd.value),
            .next_word (nxt),
            .head_word (words[0]),
            .word      (words[i]),
            .tap       (taps[i])
        );
    end

    always_comb
    begin
        removed = '0;
        for (int i = 0; i < D; i++)
        begin
            removed = removed | taps[i];
        end
    end

    always_comb
    begin
        occ_next       = occ_reg;
        listing_next   = listing_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        last_next      = last_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (enq_ok)
        begin
            occ_next = occ_reg + qwpr_pkg::OCC_W'(1);
        end
        else if (rem_ok)
        begin
            occ_next = occ_reg - qwpr_pkg::OCC_W'(1);
        end

        if (list_step)
        begin
            out_valid_next = 1'b1;
            status_next    = qwpr_pkg::ST_OK;
            data_next      = words[0];
            last_next      = list_last;
            listing_next   = !list_last;
            cnt_next       = cnt_cur + qwpr_pkg::IDX_W'(1);
        end
        else if (acc)
        begin
            data_next = '0;
            last_next = 1'b1;
            case (cmd.opcode)
                qwpr_pkg::OP_ENQ:
                begin
                    out_valid_next = 1'b1;
                    status_next    = is_full ? qwpr_pkg::ST_FULL : qwpr_pkg::ST_OK;
                end
                qwpr_pkg::OP_REM:
                begin
                    out_valid_next = 1'b1;
                    if (is_empty)
                    begin
                        status_next = qwpr_pkg::ST_EMPTY;
                    end
                    else if (beyond)
                    begin
                        status_next = qwpr_pkg::ST_BEYOND;
                    end
                    else
                    begin
                        status_next = qwpr_pkg::ST_OK;
                        data_next   = removed;
                    end
                end
                qwpr_pkg::OP_LIST:
                begin
                    // Only an empty queue reaches here; a full list goes through list_step.
                    out_valid_next = 1'b1;
                    status_next    = qwpr_pkg::ST_EMPTY;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !rsp.ready;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            listing_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            listing_reg   <= listing_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.data   = data_reg;
    assign rsp.last   = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= qwpr_pkg::OCC_W'(D))
        else $error("occupancy exceeds depth");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        listing_reg |-> (occ_reg != '0))
        else $error("list sequencer active on an empty queue");

    a_list_count: assert property (@(posedge clk) disable iff (!rst_n)
        listing_reg |-> (qwpr_pkg::OCC_W'(cnt_reg) < occ_reg))
        else $error("list count ran past occupancy");

    a_occ_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(occ_reg))
        else $error("occupancy changed without an accepted command");
endmodule
`default_nettype wire

### tb/qwpr_sb_pkg.sv
// Scoreboard for the positional-removal queue: queue predictor and expected-word checks.
package qwpr_sb_pkg;
    import qwpr_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } rsp_word_t;

    localparam int REPORT_LIMIT = 10;

    class queue_scoreboard;
        logic signed [DATA_W-1:0] queue_model[$];
        rsp_word_t                expected_words[$];
        int unsigned              errors;

        function int occupancy();
            return queue_model.size();
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Applies one accepted command to the predicted queue and records its response words.
        function void note_command(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                   logic [POS_W-1:0] position);
            int        idx;
            int        count;
            rsp_word_t word;
            count = queue_model.size();
            word.status = ST_OK;
            word.data   = '0;
            word.last   = 1'b1;
            case (op)
                OP_ENQ:
                begin
                    if (count >= DEPTH)
                        word.status = ST_FULL;
                    else
                        queue_model.push_back(value);
                    expected_words.push_back(word);
                end
                OP_REM:
                begin
                    if (count == 0)
                        word.status = ST_EMPTY;
                    else if (int'(position) > count)
                        word.status = ST_BEYOND;
                    else
                    begin
                        idx = (position == 0) ? 0 : int'(position) - 1;
                        word.data = queue_model[idx];
                        queue_model.delete(idx);
                    end
                    expected_words.push_back(word);
                end
                OP_LIST:
                begin
                    if (count == 0)
                    begin
                        word.status = ST_EMPTY;
                        expected_words.push_back(word);
                    end
                    else
                    begin
                        for (int i = 0; i < count; i++)
                        begin
                            word.data = queue_model[i];
                            word.last = (i == count - 1);
                            expected_words.push_back(word);
                        end
                    end
                end
                default:
                begin
                    // The spare opcode leaves the queue alone and answers nothing.
                end
            endcase
        endfunction

        function void check_word(logic [ST_W-1:0] status, logic signed [DATA_W-1:0] data,
                                 logic last);
            rsp_word_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR: unexpected response word status=%0d data=%0d last=%0b",
                             status, data, last);
                return;
            end
            want = expected_words.pop_front();
            if (status !== want.status || data !== want.data || last !== want.last)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"ERROR: response word mismatch: expected status=%0d data=%0d ",
                              "last=%0b, got status=%0d data=%0d last=%0b"},
                             want.status, want.data, want.last, status, data, last);
            end
        endfunction
    endclass
endpackage

### tb/tb_queue_with_positional_removal_top.sv
// Testbench top for the positional-removal queue: directed and random commands, checked per word.
module tb_queue_with_positional_removal_top;
    timeunit 1ns;
    timeprecision 1ps;

    import qwpr_pkg::*;
    import qwpr_sb_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_COMMANDS = 352;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_CYCLES     = 300;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int unsigned send_idle_pct  = 16;
    int unsigned recv_stall_pct = 59;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;
    int unsigned cycle_count    = 0;

    queue_scoreboard sb = new;

    qwpr_cmd_if cmd_ch();
    qwpr_rsp_if rsp_ch();

    queue_with_positional_removal_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // A long hold-off lets the output back up until the block refuses commands.
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Sampling at the falling edge sees exactly what the next rising edge will see.
    always @(negedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_word(rsp_ch.status, rsp_ch.data, rsp_ch.last);
    end

    task automatic send_command(input logic [OP_W-1:0] op,
                                input logic signed [DATA_W-1:0] value,
                                input logic [POS_W-1:0] position);
        logic accepted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.opcode   <= op;
        cmd_ch.value    <= value;
        cmd_ch.position <= position;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = cmd_ch.ready;
            if (accepted)
                sb.note_command(op, value, position);
            @(posedge clk);
        end
    endtask

    initial
    begin
        mix_t                     mix;
        int                       burst_left;
        int unsigned              roll;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;

        cmd_ch.valid    = 1'b0;
        cmd_ch.opcode   = OP_ENQ;
        cmd_ch.value    = '0;
        cmd_ch.position = '0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Empty queue, spare opcode, extreme values, beyond-size, head, tail and middle removal.
        send_command(OP_LIST, 32'sd0, 8'd0);
        send_command(OP_REM, 32'sd0, 8'd0);
        send_command(OP_SPARE, 32'h7FFF_FFFF, 8'hFF);
        send_command(OP_ENQ, 32'h7FFF_FFFF, 8'd0);
        send_command(OP_ENQ, 32'h8000_0000, 8'd0);
        send_command(OP_ENQ, 32'sd0, 8'd0);
        send_command(OP_ENQ, -32'sd1, 8'd0);
        send_command(OP_ENQ, 32'h1234_5678, 8'hFF);
        send_command(OP_LIST, 32'sd0, 8'd0);
        send_command(OP_REM, 32'sd0, 8'd6);
        send_command(OP_REM, 32'sd0, 8'd255);
        send_command(OP_REM, 32'sd0, 8'd5);
        send_command(OP_REM, 32'sd0, 8'd0);
        send_command(OP_REM, 32'sd0, 8'd1);
        send_command(OP_ENQ, 32'h5555_AAAA, 8'd0);
        send_command(OP_ENQ, 32'hAAAA_5555, 8'd0);
        send_command(OP_REM, 32'sd0, 8'd2);
        send_command(OP_LIST, 32'sd0, 8'd0);
        send_command(OP_REM, 32'sd0, 8'd3);

        // The first burst is enqueue-heavy so the queue reaches full early.
        mix = MIX_FILL;
        burst_left = 40;
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (n == RANDOM_COMMANDS / 3)
            begin
                send_idle_pct  <= 59;
                recv_stall_pct <= 16;
            end
            else if (n == 2 * RANDOM_COMMANDS / 3)
            begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
                hold_requests  <= hold_requests + 1;
            end
            if (burst_left == 0)
            begin
                mix = mix_t'($urandom_range(0, 2));
                burst_left = $urandom_range(8, 40);
            end
            burst_left--;
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:
                    op = (roll < 70) ? OP_ENQ : (roll < 82) ? OP_REM :
                         (roll < 97) ? OP_LIST : OP_SPARE;
                MIX_DRAIN:
                    op = (roll < 15) ? OP_ENQ : (roll < 80) ? OP_REM :
                         (roll < 96) ? OP_LIST : OP_SPARE;
                default:
                    op = (roll < 42) ? OP_ENQ : (roll < 80) ? OP_REM :
                         (roll < 97) ? OP_LIST : OP_SPARE;
            endcase
            value = $urandom;
            // Most positions land around the live range, including one past the tail.
            if ($urandom_range(0, 99) < 80)
                position = POS_W'($urandom_range(0, sb.occupancy() + 1));
            else
                position = POS_W'($urandom_range(0, 255));
            send_command(op, value, position);
        end
        cmd_ch.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
